>>> rtl/stq_pkg.sv
// Shared constants for the sorted task queue: request kinds, status codes, field widths.
`default_nettype none

package stq_pkg;

	// request kinds carried on s_tuser
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// fixed field widths of the stream payloads
	localparam int unsigned TASK_ID_W   = 8;
	localparam int unsigned TASK_PRIO_W = 8;
	localparam int unsigned SLEEP_W     = 32;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned POSITION_W  = 4;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned HEAD_ID_W   = 8;
	localparam int unsigned HEAD_KEY_W  = 32;

	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 56;
	localparam int unsigned M_PAD_W  = M_DATA_W - (STATUS_W + POSITION_W + COUNT_W + 1
		+ HEAD_ID_W + HEAD_KEY_W);

endpackage

`default_nettype wire

>>> rtl/sorted_task_queue_unit.sv
// Sorted task queue: entry memory walked by a read-modify-write sequencer.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+--------------------------------------------
//  s_      | in  | s_tvalid / s_tready      | s_tuser: req_type; s_tdata: task_id,
//          |     |                          |   task_prio, task_sleep_ticks
//  m_      | out | m_tvalid / m_tready      | m_tdata: status, position, entry_count,
//          |     |                          |   head_valid, head_id, head_key
//  cfg_    | in  | cfg_wr_en                | cfg_wr_data: list_kind
//
// One memory port reads and one writes per cycle.
// An insert walks down from the tail moving larger keys up; a delete walks up from
// the head and moves every entry after the match down one slot.
// Reset clears the entry count, list_kind and the handshakes; memory is not cleared.
// A waiting result does not block the next transaction from being accepted.
`default_nettype none

module sorted_task_queue_unit
	import stq_pkg::*;
#(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned ID_BITS  = 8,
	parameter int unsigned KEY_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_wr_data,   // list_kind
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,       // task_id[7:0], task_prio[15:8],
	                                                // task_sleep_ticks[47:16]
	input  wire logic                s_tuser,       // req_type
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata        // status[1:0], position[5:2],
	                                                // entry_count[10:6], head_valid[11],
	                                                // head_id[19:12], head_key[51:20]
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = ID_BITS + KEY_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_PUT  = 3'd2;
	localparam logic [2:0] ST_DEL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [CW-1:0]       used_q, used_d;
	logic                list_kind_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic                op_q;
	logic [ID_BITS-1:0]  id_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0]       cur_q, cur_d;
	logic [IW-1:0]       pos_q, pos_d;
	logic                found_q, found_d;
	logic [1:0]          status_q, status_d;
	logic [ID_BITS-1:0]  head_id_q;
	logic [KEY_BITS-1:0] head_key_q;

	logic [EW-1:0]       mem [DEPTH];
	logic [EW-1:0]       rd_data_q;
	logic                rd_en, we;
	logic [IW-1:0]       rd_addr, wr_addr;
	logic [EW-1:0]       wr_data;

	logic                accept;
	logic                out_load;
	logic                hit;
	logic [IW-1:0]       used_m1;
	logic [ID_BITS-1:0]  rd_id;
	logic [KEY_BITS-1:0] rd_key;
	logic [ID_BITS-1:0]  in_id;
	logic [KEY_BITS-1:0] in_key;
	logic                head_valid;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign used_m1 = IW'(used_q - CW'(1));
	assign rd_id   = rd_data_q[EW-1:KEY_BITS];
	assign rd_key  = rd_data_q[KEY_BITS-1:0];
	assign in_id   = ID_BITS'(s_tdata[TASK_ID_W-1:0]);
	assign in_key  = list_kind_q ? KEY_BITS'(s_tdata[S_DATA_W-1:TASK_ID_W+TASK_PRIO_W])
	                             : KEY_BITS'(s_tdata[TASK_ID_W+TASK_PRIO_W-1:TASK_ID_W]);
	assign head_valid = (used_q != '0);

	// sequence the walk over the entry memory
	always_comb begin
		state_d  = state_q;
		used_d   = used_q;
		cur_d    = cur_q;
		pos_d    = pos_q;
		found_d  = found_q;
		status_d = status_q;
		rd_en    = 1'b0;
		rd_addr  = cur_q;
		we       = 1'b0;
		wr_addr  = cur_q;
		wr_data  = rd_data_q;
		out_load = 1'b0;
		hit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					status_d = STATUS_OK;
					pos_d    = '0;
					found_d  = 1'b0;
					if (s_tuser == REQ_INSERT) begin
						if (used_q == CW'(DEPTH)) begin
							status_d = STATUS_FULL;
							state_d  = ST_FIN;
						end else if (used_q == '0) begin
							state_d = ST_PUT;
						end else begin
							rd_en   = 1'b1;
							rd_addr = used_m1;
							cur_d   = used_m1;
							state_d = ST_INS;
						end
					end else begin
						if (used_q == '0) begin
							status_d = STATUS_NOT_FOUND;
							state_d  = ST_FIN;
						end else begin
							rd_en   = 1'b1;
							rd_addr = '0;
							cur_d   = '0;
							state_d = ST_DEL;
						end
					end
				end
			end
			ST_INS: begin
				we      = 1'b1;
				wr_addr = cur_q + IW'(1);
				if (rd_key > key_q) begin
					// move the larger key up one slot and keep walking down, or put the new entry at the head
					if (cur_q == '0) begin
						pos_d   = '0;
						state_d = ST_PUT;
					end else begin
						cur_d   = cur_q - IW'(1);
						rd_en   = 1'b1;
						rd_addr = cur_q - IW'(1);
					end
				end else begin
					wr_data = {id_q, key_q};
					pos_d   = cur_q + IW'(1);
					used_d  = used_q + CW'(1);
					state_d = ST_FIN;
				end
			end
			ST_PUT: begin
				we      = 1'b1;
				wr_addr = pos_q;
				wr_data = {id_q, key_q};
				used_d  = used_q + CW'(1);
				state_d = ST_FIN;
			end
			ST_DEL: begin
				// after the match, pull each entry down one slot
				if (found_q) begin
					we      = 1'b1;
					wr_addr = cur_q - IW'(1);
				end
				hit = !found_q && (rd_id == id_q);
				if (hit) begin
					found_d = 1'b1;
					pos_d   = cur_q;
				end
				if (cur_q == used_m1) begin
					if (found_q || hit) begin
						used_d = used_q - CW'(1);
					end else begin
						status_d = STATUS_NOT_FOUND;
						pos_d    = '0;
					end
					state_d = ST_FIN;
				end else begin
					cur_d   = cur_q + IW'(1);
					rd_en   = 1'b1;
					rd_addr = cur_q + IW'(1);
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			list_kind_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (cfg_wr_en) begin
				list_kind_q <= cfg_wr_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// hold the request, walk position and head copy
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			id_q  <= in_id;
			key_q <= in_key;
		end
		cur_q    <= cur_d;
		pos_q    <= pos_d;
		found_q  <= found_d;
		status_q <= status_d;
		if (we && (wr_addr == '0)) begin
			head_id_q  <= wr_data[EW-1:KEY_BITS];
			head_key_q <= wr_data[KEY_BITS-1:0];
		end
		if (out_load) begin
			m_tdata_q <= {
				{M_PAD_W{1'b0}},
				head_valid ? HEAD_KEY_W'(head_key_q) : {HEAD_KEY_W{1'b0}},
				head_valid ? HEAD_ID_W'(head_id_q) : {HEAD_ID_W{1'b0}},
				head_valid,
				COUNT_W'(used_q),
				POSITION_W'(pos_q),
				status_q
			};
		end
	end

	// entry count never exceeds the memory depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// a walk never reads the entry it writes in the same cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && we) |-> (rd_addr != wr_addr))
		else $error("read and write hit the same entry");

	// the count only moves while a transaction is being worked
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> (used_q == $past(used_q)))
		else $error("entry count changed while idle");

	// a not-found status only ends a delete
	a_not_found_delete: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (status_q == STATUS_NOT_FOUND)) |-> (op_q == REQ_DELETE))
		else $error("not-found status on an insert");

endmodule

`default_nettype wire
